### design/imp_pkg.sv
// Shared types, constants and helper functions for the influence map propagation block.
package imp_pkg;

   localparam int VALUE_W  = 16;
   localparam int FACTOR_W = 16;
   localparam int GROWTH_W = 17;
   localparam int WALL_W   = 9;
   localparam int NBR_N    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int STAGE_N  = 4;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'hFFFF;
   localparam logic [GROWTH_W-1:0] GROWTH_ONE   = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE_DUAL     = 2'd0,
      CSR_ORTHO_FACTOR  = 2'd1,
      CSR_DIAG_FACTOR   = 2'd2,
      CSR_GROWTH_FACTOR = 2'd3
   } csr_index_type;

   // One scaled neighbor competing for the strongest-neighbor slot.
   typedef struct packed {
      logic                       found;
      logic [VALUE_W-1:0]         key;
      logic signed [VALUE_W-1:0]  prod;
   } cand_type;

   // The earlier candidate is passed as a; it keeps the slot on a tie.
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      r = a;
      if (b.found && (!a.found || (b.key > a.key))) begin
         r = b;
      end
      return r;
   endfunction

   // Value times Q0.16 factor, rounded half up, which always fits Q1.15.
   function automatic logic signed [VALUE_W-1:0] scale(input logic signed [VALUE_W-1:0] v,
                                                      input logic [FACTOR_W-1:0] f);
      logic signed [VALUE_W+FACTOR_W:0] prod;
      logic signed [VALUE_W+FACTOR_W:0] rnd;
      prod = v * $signed({1'b0, f});
      rnd  = (prod + $signed((VALUE_W+FACTOR_W+1)'(32768))) >>> 16;
      return rnd[VALUE_W-1:0];
   endfunction

endpackage

### design/imp_req_if.sv
// Input channel carrying one 3x3 neighborhood per beat.
interface imp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [imp_pkg::VALUE_W-1:0]   centre_value;
   logic signed [imp_pkg::VALUE_W-1:0]   up_value;
   logic signed [imp_pkg::VALUE_W-1:0]   left_value;
   logic signed [imp_pkg::VALUE_W-1:0]   right_value;
   logic signed [imp_pkg::VALUE_W-1:0]   down_value;
   logic signed [imp_pkg::VALUE_W-1:0]   up_left_value;
   logic signed [imp_pkg::VALUE_W-1:0]   up_right_value;
   logic signed [imp_pkg::VALUE_W-1:0]   down_right_value;
   logic signed [imp_pkg::VALUE_W-1:0]   down_left_value;
   logic [imp_pkg::WALL_W-1:0]           wall_mask;

   modport source (output valid, centre_value, up_value, left_value, right_value,
                   down_value, up_left_value, up_right_value, down_right_value,
                   down_left_value, wall_mask, input ready);
   modport sink (input valid, centre_value, up_value, left_value, right_value,
                 down_value, up_left_value, up_right_value, down_right_value,
                 down_left_value, wall_mask, output ready);
endinterface

### design/imp_rsp_if.sv
// Result channel carrying one propagated cell value per beat.
interface imp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [imp_pkg::VALUE_W-1:0]   new_value;

   modport source (output valid, new_value, input ready);
   modport sink (input valid, new_value, output ready);
endinterface

### design/imp_csr_if.sv
// Register write channel: register index and write data per beat.
interface imp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [imp_pkg::CSR_IDX_W-1:0]        index;
   logic [imp_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/imp_lerp.sv
// Final pipeline stage: moves the centre toward the chosen target and saturates, or gives zero for a wall centre.
module imp_lerp (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic                                 wall,
   input  logic signed [imp_pkg::VALUE_W-1:0]   centre,
   input  logic signed [imp_pkg::VALUE_W:0]     delta,
   input  logic [imp_pkg::GROWTH_W-1:0]         growth,
   output logic signed [imp_pkg::VALUE_W-1:0]   new_value
);
   import imp_pkg::*;

   logic [GROWTH_W-1:0]              growth_clamped;
   logic signed [VALUE_W+GROWTH_W+1:0] prod;
   logic signed [VALUE_W+GROWTH_W+1:0] rnd;
   logic signed [VALUE_W+3:0]        sum;
   logic signed [VALUE_W-1:0]        new_value_in;
   logic signed [VALUE_W-1:0]        new_value_ff;

   always_comb begin
      growth_clamped = (growth > GROWTH_ONE) ? GROWTH_ONE : growth;
      prod = delta * $signed({1'b0, growth_clamped});
      rnd  = (prod + $signed((VALUE_W+GROWTH_W+2)'(32768))) >>> 16;
      sum  = $signed((VALUE_W+4)'(centre)) + rnd[VALUE_W+3:0];
      if (wall) begin
         new_value_in = '0;
      end else if (sum > $signed((VALUE_W+4)'(32767))) begin
         new_value_in = 16'sh7FFF;
      end else if (sum < $signed(-(VALUE_W+4)'(32768))) begin
         new_value_in = 16'sh8000;
      end else begin
         new_value_in = sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         new_value_ff <= new_value_in;
      end
   end

   assign new_value = new_value_ff;

endmodule

### design/influence_map_propagation.sv
// Influence map propagation: one cell's next value from its 3x3 neighborhood.
// The req_ch channel takes one neighborhood per beat (centre, eight neighbors and
// a wall mask, bit 0 the centre); rsp_ch returns one new_value per beat, in order.
// The csr_ch channel writes mode_dual, ortho_factor, diag_factor and growth_factor
// by index 0 to 3; it is always ready and should be used only while the block is
// empty. Four register stages: scaling multipliers, the first two levels of the
// strongest-neighbor tree, the last tree level with the lerp difference, and the
// lerp multiplier feeding the output register. The accepting edge loads the first
// stage, and rsp_ch.valid rises once the beat reaches the output register; a new
// beat is accepted every cycle while the output is not stalled.
// When the receiver holds rsp_ch.ready low with a result waiting, the whole
// pipeline freezes and req_ch.ready drops until the result is taken; nothing is
// dropped or repeated. Reset empties the pipeline and sets the registers to solo
// mode, both decay factors to 65535 and growth to zero.
module influence_map_propagation (
   input logic    clock,
   input logic    reset,
   imp_req_if.sink   req_ch,
   imp_rsp_if.source rsp_ch,
   imp_csr_if.sink   csr_ch
);
   import imp_pkg::*;

   logic                  mode_ff;
   logic [FACTOR_W-1:0]   ortho_ff;
   logic [FACTOR_W-1:0]   diag_ff;
   logic [GROWTH_W-1:0]   growth_ff;

   logic [STAGE_N-1:0]    valid_ff;
   logic [STAGE_N-1:0]    valid_in;
   logic                  advance;
   logic                  req_beat;

   logic signed [VALUE_W-1:0] nbr [NBR_N];
   logic [NBR_N-1:0]          open_nbr;
   logic [NBR_N-1:0]          use_nbr;

   cand_type              s1_cand_in [NBR_N];
   cand_type              s1_cand_ff [NBR_N];
   logic signed [VALUE_W-1:0] s1_centre_ff;
   logic                  s1_wall_ff;

   cand_type              lvl1 [NBR_N/2];
   cand_type              s2_cand_in [2];
   cand_type              s2_cand_ff [2];
   logic signed [VALUE_W-1:0] s2_centre_ff;
   logic                  s2_wall_ff;

   cand_type              best;
   logic signed [VALUE_W-1:0] target;
   logic signed [VALUE_W:0]   s3_delta_in;
   logic signed [VALUE_W:0]   s3_delta_ff;
   logic signed [VALUE_W-1:0] s3_centre_ff;
   logic                  s3_wall_ff;

   // Register writes.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         ortho_ff  <= FACTOR_RESET;
         diag_ff   <= FACTOR_RESET;
         growth_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_MODE_DUAL:     mode_ff   <= csr_ch.data[0];
            CSR_ORTHO_FACTOR:  ortho_ff  <= csr_ch.data[FACTOR_W-1:0];
            CSR_DIAG_FACTOR:   diag_ff   <= csr_ch.data[FACTOR_W-1:0];
            CSR_GROWTH_FACTOR: growth_ff <= csr_ch.data[GROWTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage moves together unless the output is stuck.
   assign advance      = !valid_ff[STAGE_N-1] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_beat     = req_ch.valid && advance;
   assign valid_in     = {valid_ff[STAGE_N-2:0], req_beat};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: scale each neighbor and decide whether it competes.
   always_comb begin
      nbr[0] = req_ch.up_value;
      nbr[1] = req_ch.left_value;
      nbr[2] = req_ch.right_value;
      nbr[3] = req_ch.down_value;
      nbr[4] = req_ch.up_left_value;
      nbr[5] = req_ch.up_right_value;
      nbr[6] = req_ch.down_right_value;
      nbr[7] = req_ch.down_left_value;
      open_nbr = ~req_ch.wall_mask[WALL_W-1:1];
      // A diagonal needs an open orthogonal next to it to be reachable.
      use_nbr[3:0] = open_nbr[3:0];
      use_nbr[4] = open_nbr[4] && (open_nbr[0] || open_nbr[1]);
      use_nbr[5] = open_nbr[5] && (open_nbr[0] || open_nbr[2]);
      use_nbr[6] = open_nbr[6] && (open_nbr[3] || open_nbr[2]);
      use_nbr[7] = open_nbr[7] && (open_nbr[3] || open_nbr[1]);
      for (int k = 0; k < NBR_N; k++) begin
         s1_cand_in[k].prod = scale(nbr[k], (k < NBR_N/2) ? ortho_ff : diag_ff);
         if (mode_ff) begin
            s1_cand_in[k].found = use_nbr[k];
            s1_cand_in[k].key   = s1_cand_in[k].prod[VALUE_W-1] ?
                                  (~s1_cand_in[k].prod + 16'd1) : s1_cand_in[k].prod;
         end else begin
            // Solo mode only looks at positive neighbors, so the product is the key.
            s1_cand_in[k].found = use_nbr[k] && !nbr[k][VALUE_W-1] && (nbr[k] != '0);
            s1_cand_in[k].key   = s1_cand_in[k].prod;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cand_ff   <= s1_cand_in;
         s1_centre_ff <= req_ch.centre_value;
         s1_wall_ff   <= req_ch.wall_mask[0];
      end
   end

   // Stage 2: first two levels of the ordered selection tree.
   always_comb begin
      for (int i = 0; i < NBR_N/2; i++) begin
         lvl1[i] = pick(s1_cand_ff[2*i], s1_cand_ff[2*i+1]);
      end
      for (int j = 0; j < 2; j++) begin
         s2_cand_in[j] = pick(lvl1[2*j], lvl1[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_cand_ff   <= s2_cand_in;
         s2_centre_ff <= s1_centre_ff;
         s2_wall_ff   <= s1_wall_ff;
      end
   end

   // Stage 3: last tree level and the lerp target. Holding the target at the
   // centre makes the lerp return the centre unchanged.
   always_comb begin
      best = pick(s2_cand_ff[0], s2_cand_ff[1]);
      if (!mode_ff && s2_centre_ff[VALUE_W-1]) begin
         target = s2_centre_ff;
      end else if (best.found) begin
         target = best.prod;
      end else if (mode_ff) begin
         target = '0;
      end else begin
         target = s2_centre_ff;
      end
      s3_delta_in = $signed({target[VALUE_W-1], target})
                  - $signed({s2_centre_ff[VALUE_W-1], s2_centre_ff});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_delta_ff  <= s3_delta_in;
         s3_centre_ff <= s2_centre_ff;
         s3_wall_ff   <= s2_wall_ff;
      end
   end

   // Stage 4: lerp multiply into the output register.
   imp_lerp u_lerp (
      .clock     (clock),
      .advance   (advance),
      .wall      (s3_wall_ff),
      .centre    (s3_centre_ff),
      .delta     (s3_delta_ff),
      .growth    (growth_ff),
      .new_value (rsp_ch.new_value)
   );

   assign rsp_ch.valid = valid_ff[STAGE_N-1];

   // A stalled output must freeze every stage behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(valid_ff))
      else $error("pipeline moved while the output was stalled");

   // Solo-mode candidates are never negative, so their key stays below 32768.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !mode_ff && best.found |-> !best.key[VALUE_W-1])
      else $error("solo candidate with a negative product");

   // A wall centre always leaves the pipeline as zero.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && s3_wall_ff && advance |=> rsp_ch.new_value == '0)
      else $error("wall centre produced a nonzero value");

endmodule

### tb/influence_map_propagation_test.sv
// Self-checking testbench for the 3x3 influence map propagation block.
`timescale 1ns / 1ps

module influence_map_propagation_test;
   import imp_pkg::*;

   localparam int RANDOM_PER_PHASE = 150;
   localparam int RANDOM_PHASES    = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 2000;
   localparam int SETTLE_CYCLES    = 12;
   localparam int MAX_REPORTS      = 40;

   // Neighbor slots in the order the block scans them.
   localparam int NBR_UP    = 0;
   localparam int NBR_LEFT  = 1;
   localparam int NBR_RIGHT = 2;
   localparam int NBR_DOWN  = 3;
   localparam int NBR_UL    = 4;
   localparam int NBR_UR    = 5;
   localparam int NBR_DR    = 6;
   localparam int NBR_DL    = 7;

   typedef struct packed {
      logic [VALUE_W-1:0]            centre;
      logic [NBR_N-1:0][VALUE_W-1:0] nbr;
      logic [WALL_W-1:0]             wall;
   } cell_window_type;

   logic clock;
   logic reset;

   imp_req_if req_ch ();
   imp_rsp_if rsp_ch ();
   imp_csr_if csr_ch ();

   influence_map_propagation dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Register copies used for prediction.
   bit                  cfg_dual   = 1'b0;
   logic [FACTOR_W-1:0] cfg_ortho  = FACTOR_RESET;
   logic [FACTOR_W-1:0] cfg_diag   = FACTOR_RESET;
   logic [GROWTH_W-1:0] cfg_growth = '0;

   cell_window_type    pending_windows [$];
   logic [VALUE_W-1:0] expected_values [$];

   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   mismatch_count     = 0;
   int   quiet_cycles;
   int   rsp_hold_left      = 0;
   bit   hold_request       = 1'b0;
   bit   hold_ack           = 1'b0;
   logic req_beat;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint round_q16(input longint x);
      // Arithmetic shift floors, so adding one half first rounds ties upward.
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic int scale_value(input int v, input logic [FACTOR_W-1:0] f);
      return int'(round_q16(longint'(v) * longint'(f)));
   endfunction

   function automatic logic [VALUE_W-1:0] propagate_cell(input cell_window_type w);
      logic [NBR_N-1:0] open_n;
      logic [NBR_N-1:0] usable;
      int               c;
      int               v;
      int               p;
      int               best;
      bit               found;
      int               k;
      longint           g;
      longint           r;
      open_n = ~w.wall[WALL_W-1:1];
      usable = open_n;
      // A diagonal needs one of its two adjacent orthogonals open.
      usable[NBR_UL] = open_n[NBR_UL] & (open_n[NBR_UP] | open_n[NBR_LEFT]);
      usable[NBR_UR] = open_n[NBR_UR] & (open_n[NBR_UP] | open_n[NBR_RIGHT]);
      usable[NBR_DR] = open_n[NBR_DR] & (open_n[NBR_DOWN] | open_n[NBR_RIGHT]);
      usable[NBR_DL] = open_n[NBR_DL] & (open_n[NBR_DOWN] | open_n[NBR_LEFT]);
      c = int'($signed(w.centre));
      best = 0;
      found = 1'b0;
      if (w.wall[0]) begin
         return '0;
      end
      if (!cfg_dual) begin
         if (c < 0) begin
            return w.centre;
         end
         for (k = 0; k < NBR_N; k++) begin
            v = int'($signed(w.nbr[k]));
            if (usable[k] && v > 0) begin
               p = scale_value(v, (k < 4) ? cfg_ortho : cfg_diag);
               if (!found || p > best) begin
                  best = p;
                  found = 1'b1;
               end
            end
         end
         if (!found) begin
            return w.centre;
         end
      end else begin
         for (k = 0; k < NBR_N; k++) begin
            if (usable[k]) begin
               p = scale_value(int'($signed(w.nbr[k])), (k < 4) ? cfg_ortho : cfg_diag);
               if ((p < 0 ? -p : p) > (best < 0 ? -best : best)) begin
                  best = p;
               end
            end
         end
      end
      g = (cfg_growth > GROWTH_ONE) ? longint'(GROWTH_ONE) : longint'(cfg_growth);
      r = longint'(c) + round_q16((longint'(best) - longint'(c)) * g);
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      return r[VALUE_W-1:0];
   endfunction

   function automatic cell_window_type make_window(input int c, input int u, input int l,
                                                   input int rt, input int d, input int ul,
                                                   input int ur, input int dr, input int dl,
                                                   input logic [WALL_W-1:0] wall);
      cell_window_type w;
      w.centre = 16'(c);
      w.nbr    = {16'(dl), 16'(dr), 16'(ur), 16'(ul), 16'(d), 16'(rt), 16'(l), 16'(u)};
      w.wall   = wall;
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input bit mostly_positive);
      logic [VALUE_W-1:0] v;
      case ($urandom_range(9))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'h0000;
         3: v = 16'($urandom_range(8)) - 16'd4;
         default: v = 16'($urandom);
      endcase
      if (mostly_positive && v[VALUE_W-1] && $urandom_range(3) != 0) begin
         v = ~v;
      end
      return v;
   endfunction

   function automatic logic [WALL_W-1:0] pick_wall();
      logic [WALL_W-1:0] m;
      m = '0;
      case ($urandom_range(3))
         0: m = 9'($urandom);
         1: m = '0;
         2: begin
            for (int k = 1; k < WALL_W; k++) begin
               m[k] = ($urandom_range(3) == 0);
            end
         end
         default: begin
            // Mostly walled orthogonals, so the diagonal rule decides.
            m[4:1] = 4'b1111 ^ 4'(5'b1 << $urandom_range(4));
            m[8:5] = 4'($urandom);
         end
      endcase
      m[0] = m[0] | ($urandom_range(9) == 0);
      return m;
   endfunction

   function automatic cell_window_type random_window(input bit solo);
      cell_window_type w;
      w.centre = pick_value(solo);
      for (int k = 0; k < NBR_N; k++) begin
         w.nbr[k] = pick_value(solo);
      end
      w.wall = pick_wall();
      return w;
   endfunction

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_MODE_DUAL:     cfg_dual   = data[0];
         CSR_ORTHO_FACTOR:  cfg_ortho  = data[FACTOR_W-1:0];
         CSR_DIAG_FACTOR:   cfg_diag   = data[FACTOR_W-1:0];
         CSR_GROWTH_FACTOR: cfg_growth = data[GROWTH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Unused upper data bits are randomized; the block must ignore them.
   task automatic configure(input bit dual, input int ortho, input int diag, input int growth);
      write_register(CSR_MODE_DUAL, {16'($urandom), dual});
      write_register(CSR_ORTHO_FACTOR, {1'($urandom), 16'(ortho)});
      write_register(CSR_DIAG_FACTOR, {1'($urandom), 16'(diag)});
      write_register(CSR_GROWTH_FACTOR, 17'(growth));
   endtask

   // The short delay lets the driver's falling-edge updates land before the check.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (pending_windows.size() != 0 || req_ch.valid || expected_values.size() != 0);
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
         default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
   endtask

   task automatic push_directed();
      pending_windows.push_back(make_window(0, 32767, 32767, 32767, 32767,
                                            32767, 32767, 32767, 32767, 9'h000));
      pending_windows.push_back(make_window(32767, -32768, -32768, -32768, -32768,
                                            -32768, -32768, -32768, -32768, 9'h000));
      pending_windows.push_back(make_window(1000, 5000, 5000, 5000, 5000,
                                            5000, 5000, 5000, 5000, 9'h001));
      pending_windows.push_back(make_window(-32768, 20000, 20000, 20000, 20000,
                                            20000, 20000, 20000, 20000, 9'h000));
      pending_windows.push_back(make_window(100, 30000, 30000, 30000, 30000,
                                            30000, 30000, 30000, 30000, 9'h1FE));
      pending_windows.push_back(make_window(0, 30000, 30000, 30000, 30000,
                                            30000, -30000, 30000, -30000, 9'h01E));
      // Only up open: up-left counts through it, down-right has no open orthogonal.
      pending_windows.push_back(make_window(50, 100, 7, 7, 7,
                                            30000, 7, 32000, 7, 9'h15C));
      pending_windows.push_back(make_window(3, 1001, 1001, 1001, 1001,
                                            1001, 1001, 1001, 1001, 9'h000));
      pending_windows.push_back(make_window(0, 1000, -1000, 0, 0,
                                            0, 0, 0, 0, 9'h000));
      pending_windows.push_back(make_window(5000, -30000, 20000, 29999, -29999,
                                            -32768, 32767, 12345, -12345, 9'h000));
      pending_windows.push_back(make_window(-1, 1, -1, 3, -3,
                                            32767, -32767, -32768, 2, 9'h000));
      pending_windows.push_back(make_window(1, 32767, 32767, -5, 32767,
                                            32767, -32768, 32767, 32767, 9'h136));
   endtask

   always @(negedge clock) begin : req_driver
      cell_window_type next_window;
      if (!reset && (!req_ch.valid || req_beat)) begin
         if (pending_windows.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_window = pending_windows.pop_front();
            req_ch.valid            <= 1'b1;
            req_ch.centre_value     <= next_window.centre;
            req_ch.up_value         <= next_window.nbr[NBR_UP];
            req_ch.left_value       <= next_window.nbr[NBR_LEFT];
            req_ch.right_value      <= next_window.nbr[NBR_RIGHT];
            req_ch.down_value       <= next_window.nbr[NBR_DOWN];
            req_ch.up_left_value    <= next_window.nbr[NBR_UL];
            req_ch.up_right_value   <= next_window.nbr[NBR_UR];
            req_ch.down_right_value <= next_window.nbr[NBR_DR];
            req_ch.down_left_value  <= next_window.nbr[NBR_DL];
            req_ch.wall_mask        <= next_window.wall;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_driver
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ch.ready  <= 1'b0;
      end else if (hold_request != hold_ack) begin
         hold_ack      <= hold_request;
         rsp_hold_left <= LONG_HOLD_CYCLES;
         rsp_ch.ready  <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : scoreboard
      cell_window_type    seen;
      logic [VALUE_W-1:0] want;
      if (reset) begin
         req_beat     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_beat <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.centre = req_ch.centre_value;
            seen.nbr    = {req_ch.down_left_value, req_ch.down_right_value,
                           req_ch.up_right_value, req_ch.up_left_value, req_ch.down_value,
                           req_ch.right_value, req_ch.left_value, req_ch.up_value};
            seen.wall   = req_ch.wall_mask;
            expected_values.push_back(propagate_cell(seen));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("%0t: unexpected new_value beat, expected none, actual %0d",
                           $time, $signed(rsp_ch.new_value));
               end
               mismatch_count++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_ch.new_value !== want) begin
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("%0t: new_value mismatch, expected %0d, actual %0d",
                              $time, $signed(want), $signed(rsp_ch.new_value));
                  end
                  mismatch_count++;
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      bit dual;
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.centre_value     = '0;
      req_ch.up_value         = '0;
      req_ch.left_value       = '0;
      req_ch.right_value      = '0;
      req_ch.down_value       = '0;
      req_ch.up_left_value    = '0;
      req_ch.up_right_value   = '0;
      req_ch.down_right_value = '0;
      req_ch.down_left_value  = '0;
      req_ch.wall_mask        = '0;
      rsp_ch.ready            = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.index            = CSR_MODE_DUAL;
      csr_ch.data             = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A few cells under the reset register values.
      for (int i = 0; i < 20; i++) begin
         pending_windows.push_back(random_window(1'b1));
      end
      wait_drained();

      configure(1'b0, 65535, 32768, 65536);
      set_idling(0);
      push_directed();
      wait_drained();
      configure(1'b1, 40000, 32768, 49152);
      set_idling(3);
      push_directed();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: configure(1'b0, 65535, 65535, 65536);
            1: configure(1'b1, 65535, 65535, 65536);
            2: configure(1'b0, 0, 0, 32768);
            3: configure(1'b1, 0, 65535, 131071);
            4: configure(1'b0, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65536));
            5: configure(1'b1, $urandom_range(65535), $urandom_range(65535), 0);
            6: configure(1'b1, 65535, 0, 65535);
            7: configure(1'b0, $urandom_range(65535), $urandom_range(65535), 131071);
            8: configure(1'b1, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(131071));
            default: configure(1'b0, 32768, 46341, 20000);
         endcase
         set_idling(phase);
         // Hold the result side off while the sender keeps offering cells.
         if (phase == 4) begin
            hold_request = ~hold_request;
         end
         dual = cfg_dual;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pending_windows.push_back(random_window(!dual));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_values.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
